// ===== rtl/rsng_pkg.sv =====
// ----------------------------------------------------------------------------
// rsng_pkg
// Shared types, constants and helper functions of the scale note generator.
// ----------------------------------------------------------------------------
package rsng_pkg;

    localparam int SEED_W     = 32;
    localparam int NOTE_W     = 7;
    localparam int REM_W      = 6;
    localparam int PC_W       = 4;
    localparam int MASK_W     = 12;
    localparam int KEY_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam int REDUCE_STEPS = SEED_W / 2;
    localparam int STEP_W       = $clog2(REDUCE_STEPS);

    localparam logic [SEED_W-1:0] DEFAULT_SEED  = 32'h6D2B_79F5;
    localparam logic [NOTE_W-1:0] NOTE_BASE     = 7'd48;
    localparam logic [PC_W-1:0]   PC_LAST       = 4'd11;
    localparam logic [PC_W-1:0]   PITCH_CLASSES = 4'd12;
    localparam logic [MASK_W-1:0] MASK_RESET    = 12'hFFF;
    localparam logic [KEY_W-1:0]  KEY_RESET     = 4'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEY  = 1'b1;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_DRAW = 1'b1;

    typedef logic [NOTE_W-1:0] note_t;
    typedef logic [REM_W-1:0]  rem_t;
    typedef logic [PC_W-1:0]   pc_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [KEY_W-1:0]  key;
    } cfg_t;

    typedef struct packed {
        logic valid;
        rem_t rem;
    } push_t;

    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // one radix-4 step of a running remainder mod 36; x < 144
    function automatic rem_t mod36_step(input logic [7:0] x);
        logic [7:0] r;
        priority if (x >= 8'd108) r = x - 8'd108;
        else if (x >= 8'd72) r = x - 8'd72;
        else if (x >= 8'd36) r = x - 8'd36;
        else r = x;
        return r[REM_W-1:0];
    endfunction

    // pitch class of a remainder below 36 (note base is a multiple of 12)
    function automatic pc_t pc_of_rem(input rem_t x);
        rem_t r;
        priority if (x >= 6'd24) r = x - 6'd24;
        else if (x >= 6'd12) r = x - 6'd12;
        else r = x;
        return r[PC_W-1:0];
    endfunction

    function automatic pc_t key_mod12(input logic [KEY_W-1:0] k);
        return (k >= PITCH_CLASSES) ? (k - PITCH_CLASSES) : k;
    endfunction

endpackage

// ===== rtl/rsng_if.sv =====
// ----------------------------------------------------------------------------
// rsng_if
// Valid/ready channels of the scale note generator: command and result.
// ----------------------------------------------------------------------------
interface rsng_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [rsng_pkg::SEED_W-1:0]  seed;

    modport source (output valid, output action, output seed, input ready);
    modport sink   (input valid, input action, input seed, output ready);
endinterface

interface rsng_res_if;
    logic                  valid;
    logic                  ready;
    rsng_pkg::note_t       note;

    modport source (output valid, output note, input ready);
    modport sink   (input valid, input note, output ready);
endinterface

// ===== rtl/rsng_front.sv =====
// ----------------------------------------------------------------------------
// rsng_front
// Accepts items, runs the xorshift generator and reduces a draw mod 36.
// ----------------------------------------------------------------------------
module rsng_front (
    input  logic                 clk,
    input  logic                 rst_n,
    rsng_cmd_if.sink             cmd,
    output rsng_pkg::push_t      push,
    input  logic                 push_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PUSH
    } state_t;

    state_t                          state_reg, state_next;
    logic [rsng_pkg::SEED_W-1:0]     gen_reg, gen_next;
    logic [rsng_pkg::SEED_W-1:0]     val_reg, val_next;
    rsng_pkg::rem_t                  rem_reg, rem_next;
    logic [rsng_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [rsng_pkg::SEED_W-1:0]     drawn;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign drawn     = rsng_pkg::xorshift(gen_reg);

    assign push.valid = (state_reg == ST_PUSH);
    assign push.rem   = rem_reg;

    always_comb
    begin
        state_next = state_reg;
        gen_next   = gen_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.action == rsng_pkg::ACTION_LOAD)
                    begin
                        gen_next = (cmd.seed == '0) ? rsng_pkg::DEFAULT_SEED : cmd.seed;
                    end
                    else
                    begin
                        gen_next   = drawn;
                        val_next   = drawn;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                rem_next  = rsng_pkg::mod36_step({rem_reg, val_reg[rsng_pkg::SEED_W-1 -: 2]});
                val_next  = val_reg << 2;
                step_next = step_reg + 1'b1;
                if (step_reg == rsng_pkg::STEP_W'(rsng_pkg::REDUCE_STEPS - 1))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gen_reg   <= rsng_pkg::DEFAULT_SEED;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != '0)
        else $error("generator state reached zero");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (rem_reg < 6'd36))
        else $error("remainder out of range");

endmodule

// ===== rtl/rsng_fifo.sv =====
// ----------------------------------------------------------------------------
// rsng_fifo
// Short queue of drawn remainders between the front and the snap unit.
// ----------------------------------------------------------------------------
module rsng_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rsng_pkg::push_t   push,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output rsng_pkg::rem_t    head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rsng_pkg::rem_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.rem;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && full) |=> (push.valid && $stable(push.rem)))
        else $error("item dropped while queue full");

endmodule

// ===== rtl/rsng_snap.sv =====
// ----------------------------------------------------------------------------
// rsng_snap
// Snaps a drawn note to the nearest allowed scale pitch, one distance a cycle.
// ----------------------------------------------------------------------------
module rsng_snap (
    input  logic              clk,
    input  logic              rst_n,
    input  rsng_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  rsng_pkg::rem_t    q_rem,
    output logic              q_pop,
    rsng_res_if.source        res
);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t              state_reg, state_next;
    rsng_pkg::note_t     midi_reg, midi_next;
    rsng_pkg::pc_t       dist_reg, dist_next;
    rsng_pkg::pc_t       pc_up_reg, pc_up_next;
    rsng_pkg::pc_t       pc_dn_reg, pc_dn_next;
    logic                out_valid_reg, out_valid_next;
    rsng_pkg::note_t     note_reg, note_next;

    rsng_pkg::pc_t       key_pc;
    rsng_pkg::pc_t       deg_up, deg_dn;
    logic                up_ok, dn_ok, done, slot_free;
    rsng_pkg::note_t     found;

    assign key_pc = rsng_pkg::key_mod12(cfg.key);
    assign deg_up = (pc_up_reg >= key_pc) ? (pc_up_reg - key_pc)
                                          : (pc_up_reg + rsng_pkg::PITCH_CLASSES - key_pc);
    assign deg_dn = (pc_dn_reg >= key_pc) ? (pc_dn_reg - key_pc)
                                          : (pc_dn_reg + rsng_pkg::PITCH_CLASSES - key_pc);
    assign up_ok  = cfg.mask[deg_up];
    assign dn_ok  = (dist_reg != '0) && cfg.mask[deg_dn];
    assign done   = up_ok || dn_ok || (dist_reg == rsng_pkg::PC_LAST);

    always_comb
    begin
        priority if (up_ok) found = midi_reg + rsng_pkg::NOTE_W'(dist_reg);
        else if (dn_ok) found = midi_reg - rsng_pkg::NOTE_W'(dist_reg);
        else found = midi_reg;
    end

    assign slot_free = !out_valid_reg || res.ready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign res.valid = out_valid_reg;
    assign res.note  = note_reg;

    always_comb
    begin
        state_next     = state_reg;
        midi_next      = midi_reg;
        dist_next      = dist_reg;
        pc_up_next     = pc_up_reg;
        pc_dn_next     = pc_dn_reg;
        note_next      = note_reg;
        out_valid_next = out_valid_reg && !res.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    midi_next  = rsng_pkg::NOTE_BASE + rsng_pkg::NOTE_W'(q_rem);
                    dist_next  = '0;
                    pc_up_next = rsng_pkg::pc_of_rem(q_rem);
                    pc_dn_next = rsng_pkg::pc_of_rem(q_rem);
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (done)
                begin
                    if (slot_free)
                    begin
                        note_next      = found;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    dist_next  = dist_reg + 1'b1;
                    pc_up_next = (pc_up_reg == rsng_pkg::PC_LAST) ? '0 : pc_up_reg + 1'b1;
                    pc_dn_next = (pc_dn_reg == '0) ? rsng_pkg::PC_LAST : pc_dn_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        midi_reg  <= midi_next;
        dist_reg  <= dist_next;
        pc_up_reg <= pc_up_next;
        pc_dn_reg <= pc_dn_next;
        note_reg  <= note_next;
    end

    a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (note_reg >= 7'd37 && note_reg <= 7'd94))
        else $error("snapped note out of range");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (dist_reg <= rsng_pkg::PC_LAST))
        else $error("search distance past last pitch class");

endmodule

// ===== rtl/random_scale_note_generator.sv =====
// ----------------------------------------------------------------------------
// random_scale_note_generator
// Random note source quantized to a configurable scale.
// ----------------------------------------------------------------------------
// A load item only reloads the generator and leaves the front idle. A draw
// item occupies the front for the accept, sixteen radix-4 steps that reduce
// the 32-bit xorshift value mod 36, and the push into the queue, which waits
// while the queue is full; no new item is accepted before the push is done.
// The snap unit then takes the item and probes distances until the note
// lands in the output register, overlapped with the next draw in the front.
module random_scale_note_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rsng_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsng_pkg::CFG_DATA_W-1:0]   cfg_data,
    rsng_cmd_if.sink                          cmd,
    rsng_res_if.source                        res
);

    rsng_pkg::cfg_t     cfg_reg;
    rsng_pkg::push_t    push;
    logic               q_full, q_empty, q_pop;
    rsng_pkg::rem_t     q_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mask <= rsng_pkg::MASK_RESET;
            cfg_reg.key  <= rsng_pkg::KEY_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rsng_pkg::CFG_IDX_MASK: cfg_reg.mask <= cfg_data[rsng_pkg::MASK_W-1:0];
                rsng_pkg::CFG_IDX_KEY:  cfg_reg.key  <= cfg_data[rsng_pkg::KEY_W-1:0];
                default:                cfg_reg      <= cfg_reg;
            endcase
        end
    end

    rsng_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push       (push),
        .push_ready (!q_full)
    );

    rsng_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_rem)
    );

    rsng_snap u_snap (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_rem   (q_rem),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule
